>>> rtl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
package mlr_pkg;

  localparam int COORD_BITS = 10;
  // Doubled midpoint term: sign bit plus headroom for twice a delta.
  localparam int DEC_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic   operation;
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    logic   last_pixel;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch ordered endpoints and deltas
    logic setup;    // choose octant, seed decision, emit start pixel
    logic step;     // advance one pixel, or emit an idle item
  } cmd_t;

endpackage

>>> rtl/mlr_ctrl.sv
// Controller: input/output handshake and load sequencing.
module mlr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_operation,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output mlr_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_READY = 2'b01,
    S_SETUP = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;
  logic   out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_READY) && out_free);
  assign accept   = in_valid && !in_stall;

  assign cmd.capture = accept && (in_operation == mlr_pkg::OP_LOAD);
  assign cmd.step    = accept && (in_operation == mlr_pkg::OP_STEP);
  assign cmd.setup   = (state == S_SETUP) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_READY: begin
        if (cmd.capture) state_next = S_SETUP;
      end
      S_SETUP: begin
        if (out_free) state_next = S_READY;
      end
      default: state_next = S_READY;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.step || cmd.setup) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_READY;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/mlr_datapath.sv
// Datapath: line state, midpoint decision arithmetic and output register.
module mlr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  mlr_pkg::cmd_t      cmd,
  input  mlr_pkg::in_item_t  in_data,
  output mlr_pkg::out_item_t out_data
);

  mlr_pkg::coord_t cur_x, cur_y, target_x, target_y;
  mlr_pkg::coord_t delta_x, delta_y_abs;
  mlr_pkg::dec_t   decision, inc_pos, inc_neg;
  logic            y_descends, y_major, active;

  // Capture: order endpoints so x rises.
  logic            swap;
  mlr_pkg::coord_t ax, ay, bx, by;

  assign swap = in_data.first_x > in_data.second_x;
  assign ax   = swap ? in_data.second_x : in_data.first_x;
  assign ay   = swap ? in_data.second_y : in_data.first_y;
  assign bx   = swap ? in_data.first_x  : in_data.second_x;
  assign by   = swap ? in_data.first_y  : in_data.second_y;

  // Setup: octant and decision seed.
  logic            ym_s;
  mlr_pkg::coord_t minor_s, major_s;
  mlr_pkg::dec_t   minor2_s, major_e_s;
  logic            active_s;

  assign ym_s      = !(delta_x > delta_y_abs);
  assign minor_s   = ym_s ? delta_x : delta_y_abs;
  assign major_s   = ym_s ? delta_y_abs : delta_x;
  assign minor2_s  = {2'b00, minor_s, 1'b0};
  assign major_e_s = {3'b000, major_s};
  assign active_s  = ym_s ? (cur_y != target_y) : (cur_x != target_x);

  // Step: one unit on the major axis, minor axis when decision >= 0.
  logic            dec_neg, move_x, move_y, active_n;
  mlr_pkg::coord_t nx, ny;
  mlr_pkg::dec_t   dec_n;

  assign dec_neg  = decision[mlr_pkg::DEC_BITS-1];
  assign move_x   = !y_major || !dec_neg;
  assign move_y   = y_major || !dec_neg;
  assign nx       = move_x ? cur_x + 1'b1 : cur_x;
  assign ny       = !move_y ? cur_y : (y_descends ? cur_y - 1'b1 : cur_y + 1'b1);
  assign dec_n    = decision + (dec_neg ? inc_pos : inc_neg);
  assign active_n = y_major ? (ny != target_y) : (nx != target_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.setup) begin
      active <= active_s;
    end else if (cmd.step && active) begin
      active <= active_n;
    end else if (cmd.capture) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_x       <= ax;
      cur_y       <= ay;
      target_x    <= bx;
      target_y    <= by;
      delta_x     <= bx - ax;
      y_descends  <= ay > by;
      delta_y_abs <= (ay > by) ? ay - by : by - ay;
    end
    if (cmd.setup) begin
      y_major              <= ym_s;
      decision             <= minor2_s - major_e_s;
      inc_pos              <= minor2_s;
      inc_neg              <= minor2_s - (major_e_s <<< 1);
      out_data.pixel_x     <= cur_x;
      out_data.pixel_y     <= cur_y;
      out_data.pixel_valid <= 1'b1;
      out_data.last_pixel  <= !active_s;
    end
    if (cmd.step) begin
      if (active) begin
        cur_x                <= nx;
        cur_y                <= ny;
        decision             <= dec_n;
        out_data.pixel_x     <= nx;
        out_data.pixel_y     <= ny;
        out_data.pixel_valid <= 1'b1;
        out_data.last_pixel  <= !active_n;
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

>>> rtl/midpoint_line_rasterizer.sv
// Top level of the midpoint line rasterizer: controller plus datapath.
//
// Input channel (in_valid/in_stall/in_data): one item is either a load,
// carrying two endpoints, or a step. Output channel (out_valid/out_stall/
// out_data): exactly one result item per input item, in order.
// A load orders the endpoints so x rises and returns the start pixel;
// each step returns the next pixel of the line, chosen by a doubled
// integer midpoint term in x-major or y-major octants. The end pixel
// carries last_pixel; a step with no line in progress returns an item
// with pixel_valid low and all other fields zero.
// Timing: a step's result is registered on the next edge, so steps stream
// at one pixel per clock while out_stall is low. A load runs as capture,
// which orders endpoints and forms the deltas, then setup, which picks the
// octant and seeds the decision term; in_stall is high during setup.
// The single output register parts the two sides: while out_stall holds
// a result, in_stall is raised and all state holds.
// Reset (rst, synchronous) leaves the block idle with no line active and
// the output register empty.
module midpoint_line_rasterizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mlr_pkg::out_item_t out_data
);

  mlr_pkg::cmd_t cmd;

  mlr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_operation (in_data.operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  mlr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // A load always passes through setup with the input held off.
  a_load_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.operation == mlr_pkg::OP_LOAD) |=> in_stall)
    else $error("load not followed by setup stall");

  // A step's result appears in the output register on the next cycle.
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.operation == mlr_pkg::OP_STEP) |=> out_valid)
    else $error("step gave no result");

  // Only a real pixel can close a line.
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_pixel) |-> out_data.pixel_valid)
    else $error("last_pixel without pixel_valid");

  // An idle item carries zero coordinates.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.pixel_valid) |->
      (out_data.pixel_x == '0 && out_data.pixel_y == '0))
    else $error("idle item with coordinates");

endmodule

>>> tb/mlr_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker: tracks the line state, predicts each pixel and compares it with the output.
module mlr_pixel_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mlr_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  mlr_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 pending
);

  // Line state: current pixel, end pixel, deltas and the doubled midpoint term.
  mlr_pkg::coord_t              cur_x, cur_y, end_x, end_y;
  logic [mlr_pkg::COORD_BITS:0] run_x, rise_y;
  int                           decision;
  logic                         y_falls, steep, drawing;

  mlr_pkg::out_item_t expected_pixels[$];

  function automatic logic reached_end();
    return steep ? (cur_y == end_y) : (cur_x == end_x);
  endfunction

  task automatic trace_pixel(input mlr_pkg::in_item_t item, output mlr_pkg::out_item_t px);
    mlr_pkg::coord_t ax, ay, bx, by, tmp;
    px = '0;
    if (item.operation == mlr_pkg::OP_LOAD) begin
      ax = item.first_x;
      ay = item.first_y;
      bx = item.second_x;
      by = item.second_y;
      // order the endpoints so that x rises
      if (ax > bx) begin
        tmp = ax; ax = bx; bx = tmp;
        tmp = ay; ay = by; by = tmp;
      end
      cur_x   = ax;
      cur_y   = ay;
      end_x   = bx;
      end_y   = by;
      run_x   = {1'b0, bx - ax};
      y_falls = ay > by;
      rise_y  = y_falls ? {1'b0, ay - by} : {1'b0, by - ay};
      steep   = !(run_x > rise_y);
      decision = steep ? 2 * int'(run_x) - int'(rise_y)
                       : 2 * int'(rise_y) - int'(run_x);
      drawing = !reached_end();
      px = '{pixel_x: cur_x, pixel_y: cur_y, pixel_valid: 1'b1, last_pixel: !drawing};
    end else if (drawing) begin
      if (steep) begin
        cur_y = y_falls ? cur_y - 1'b1 : cur_y + 1'b1;
        if (decision < 0) begin
          decision += 2 * int'(run_x);
        end else begin
          decision += 2 * (int'(run_x) - int'(rise_y));
          cur_x = cur_x + 1'b1;
        end
      end else begin
        cur_x = cur_x + 1'b1;
        if (decision < 0) begin
          decision += 2 * int'(rise_y);
        end else begin
          decision += 2 * (int'(rise_y) - int'(run_x));
          cur_y = y_falls ? cur_y - 1'b1 : cur_y + 1'b1;
        end
      end
      drawing = !reached_end();
      px = '{pixel_x: cur_x, pixel_y: cur_y, pixel_valid: 1'b1, last_pixel: !drawing};
    end
    // a step with no line in progress leaves px all zero
  endtask

  task automatic check_field(input string field, input logic [mlr_pkg::COORD_BITS-1:0] want,
                             input logic [mlr_pkg::COORD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    mlr_pkg::out_item_t want;
    if (rst) begin
      cur_x      = '0;
      cur_y      = '0;
      end_x      = '0;
      end_y      = '0;
      run_x      = '0;
      rise_y     = '0;
      decision   = 0;
      y_falls    = 1'b0;
      steep      = 1'b0;
      drawing    = 1'b0;
      mismatches = 0;
      expected_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel item with no input item outstanding");
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.pixel_x, out_data.pixel_x);
          check_field("pixel_y", want.pixel_y, out_data.pixel_y);
          check_field("pixel_valid", mlr_pkg::coord_t'(want.pixel_valid),
                      mlr_pkg::coord_t'(out_data.pixel_valid));
          check_field("last_pixel", mlr_pkg::coord_t'(want.last_pixel),
                      mlr_pkg::coord_t'(out_data.last_pixel));
        end
      end
      if (in_valid && !in_stall) begin
        trace_pixel(in_data, want);
        expected_pixels.push_back(want);
      end
    end
    pending = expected_pixels.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the line rasterizer: clock, reset, stimulus, output stalls, verdict.
module tb;

  localparam int              ITEM_TARGET     = 1250;
  localparam int              CYCLE_LIMIT     = 600000;
  localparam int              HOLD_OFF_CYCLES = 300;
  localparam int              HOLD_OFF_AFTER  = 400;
  localparam int              DRAIN_CYCLES    = 20;
  localparam mlr_pkg::coord_t COORD_MAX       = '1;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid, in_stall;
  mlr_pkg::in_item_t  in_data;
  logic               out_valid, out_stall;
  mlr_pkg::out_item_t out_data;

  int   mismatches, pending;
  int   sent;
  int   cycle_count;
  // quiet: a stretch with no idling on either side
  logic quiet         = 1'b0;
  // long receiver hold-off, requested by the stimulus, done by the receiver
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;

  midpoint_line_rasterizer uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  mlr_pixel_checker pixel_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coordinates sit on the edges now and then so the extremes turn up often.
  function automatic mlr_pkg::coord_t rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return COORD_MAX;
    return mlr_pkg::coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  // A point within reach of base, clipped to the coordinate range.
  function automatic mlr_pkg::coord_t near(input mlr_pkg::coord_t base, input int reach);
    int pos;
    pos = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
    if (pos < 0) pos = 0;
    else if (pos > int'(COORD_MAX)) pos = int'(COORD_MAX);
    return mlr_pkg::coord_t'(pos);
  endfunction

  // Steps after the load until the end pixel: length along the major axis.
  function automatic int line_span(input mlr_pkg::coord_t ax, ay, bx, by);
    int sx, sy;
    sx = (ax > bx) ? int'(ax) - int'(bx) : int'(bx) - int'(ax);
    sy = (ay > by) ? int'(ay) - int'(by) : int'(by) - int'(ay);
    return (sx > sy) ? sx : sy;
  endfunction

  function automatic mlr_pkg::in_item_t load_item(input mlr_pkg::coord_t ax, ay, bx, by);
    return '{operation: mlr_pkg::OP_LOAD, first_x: ax, first_y: ay, second_x: bx,
             second_y: by};
  endfunction

  // Endpoint fields of a step are don't-care, so fill them with noise.
  function automatic mlr_pkg::in_item_t step_item();
    mlr_pkg::in_item_t item;
    logic [63:0]       noise;
    noise = {$urandom, $urandom};
    item = noise[$bits(mlr_pkg::in_item_t)-1:0];
    item.operation = mlr_pkg::OP_STEP;
    return item;
  endfunction

  // Offer one item after a random gap and hold it until accepted.
  // Starts and ends at a falling edge, so valid and data get one update per step.
  task automatic offer(input mlr_pkg::in_item_t item);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic draw_line(input mlr_pkg::coord_t ax, ay, bx, by, input int steps);
    offer(load_item(ax, ay, bx, by));
    repeat (steps) offer(step_item());
  endtask

  // Receiver: random stalls with stall-free runs between, plus one long hold-off
  // while the sender keeps offering, so the block backs up onto its input.
  initial begin : receiver
    int stall_len, held;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_off_done = 1'b1;
      end else begin
        stall_len = idle_len();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Run limit, well above the slowest correct run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    mlr_pkg::coord_t ax, ay, bx, by;
    int              span, steps, pick;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    sent     = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part.
    // step straight after reset: nothing active, so an invalid pixel
    offer(step_item());
    // single point at the origin, then a step on the now idle block
    draw_line('0, '0, '0, '0, 1);
    // single point at the far corner
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    // horizontal, x-major with no minor movement
    draw_line(10'd5, 10'd5, 10'd8, 10'd5, 3);
    // vertical with y falling: y-major, decision always negative
    draw_line(10'd3, 10'd9, 10'd3, 10'd6, 3);
    // 45 degrees, endpoints given right to left: swapped, drawn y-major
    draw_line(10'd6, 10'd6, 10'd3, 10'd3, 3);
    // shallow x-major line with y falling from the top edge
    draw_line('0, COORD_MAX, 10'd5, 10'd1021, 5);
    // full-diagonal line, dropped after one step by the next load
    draw_line(COORD_MAX, '0, '0, COORD_MAX, 1);

    // Random part: mostly complete short lines with random endpoints.
    while (sent < ITEM_TARGET) begin
      if (sent >= HOLD_OFF_AFTER) hold_off_req = 1'b1;
      if ($urandom_range(0, 15) == 0) quiet = ~quiet;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // stray steps, mostly on an idle block
        repeat ($urandom_range(1, 3)) offer(step_item());
      end else if (pick < 14) begin
        // full-range endpoints, cut short by the next load
        draw_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  $urandom_range(0, 6));
      end else begin
        ax = rand_coord();
        ay = rand_coord();
        if (pick < 16) begin
          // the odd longer line
          bx = near(ax, 150);
          by = near(ay, 150);
        end else begin
          bx = near(ax, 15);
          by = near(ay, 15);
        end
        span = line_span(ax, ay, bx, by);
        pick = $urandom_range(0, 99);
        // run to the end, overrun into idle steps, or get interrupted
        if (pick < 75) steps = span;
        else if (pick < 88) steps = span + $urandom_range(1, 3);
        else steps = $urandom_range(0, span);
        draw_line(ax, ay, bx, by, steps);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected pixel, then for any stray items.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
